// File: rtl/tcur_pkg.sv
// Shared types and constants for the text terminal cursor engine.
// Holds character codes, the result record, the store-side state codes and sizing helpers.
// No dependencies.
`default_nettype none

package tcur_pkg;

  // Default screen geometry limits
  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_MAX_ROWS = 64;

  // Configuration register widths and reset values
  localparam int CFG_COLS_W = 8;
  localparam int CFG_ROWS_W = 7;
  localparam logic [CFG_COLS_W-1:0] CFG_COLS_RESET = 8'd80;
  localparam logic [CFG_ROWS_W-1:0] CFG_ROWS_RESET = 7'd25;

  // Register indexes on the configuration port
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // Control character codes
  localparam logic [7:0] CH_NUL       = 8'd0;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;

  // Cell written by backspace and by the scroll fill: space on attribute 0
  localparam logic [15:0] BLANK_ENTRY = 16'h0020;
  localparam logic [15:0] CLEAR_ENTRY = 16'h0000;

  // Queue depths
  localparam int CMD_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH = 2;

  // One result item
  typedef struct packed {
    logic        cell_written;
    logic [12:0] cell_index;
    logic [15:0] cell_entry;
    logic        scrolled;
    logic [6:0]  cursor_col;
    logic [5:0]  cursor_row;
  } result_t;

  // Status of the store side seen by the front
  typedef struct packed {
    logic clearing;
  } bk_status_t;

  // Store sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_COPY,
    BK_BLANK
  } bk_state_t;

  // Width of one store command: write flag, scroll flag, index, entry, columns, rows
  function automatic int cmd_width(input int max_cols, input int max_rows);
    cmd_width = 2 + $clog2(max_cols * max_rows) + 16 + $clog2(max_cols + 1)
                + $clog2(max_rows + 1);
  endfunction

endpackage

`default_nettype wire

// File: rtl/tcur_fifo.sv
// Small first-in first-out queue used for store commands and for finished results.
// Stand-alone; no package dependency.
`default_nettype none

module tcur_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic              full,
  output logic              empty,
  output logic [W-1:0]      head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = data_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & ~empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tcur_front.sv
// Front of the terminal engine: takes items, moves the cursor and forms the result.
// Issues cell writes and scrolls to the store side as commands.
// Depends on tcur_pkg and tcur_fifo.
`default_nettype none

module tcur_front #(
  parameter int MAX_COLS = tcur_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tcur_pkg::DEF_MAX_ROWS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [7:0]                             in_char_code,
  input  wire logic [7:0]                             in_attribute,
  input  wire logic [tcur_pkg::CFG_COLS_W-1:0]        cols_cfg,
  input  wire logic [tcur_pkg::CFG_ROWS_W-1:0]        rows_cfg,
  input  wire tcur_pkg::bk_status_t                   bk_status,
  input  wire logic                                   cmd_full,
  output logic                                        cmd_push,
  output logic [tcur_pkg::cmd_width(MAX_COLS, MAX_ROWS)-1:0] cmd_data,
  output logic                                        res_valid,
  input  wire logic                                   res_stall,
  output tcur_pkg::result_t                           res
);

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int IDX_W  = $clog2(MAX_COLS * MAX_ROWS);
  localparam int CE     = CNT_W + tcur_pkg::CFG_COLS_W;
  localparam int RE     = RCNT_W + tcur_pkg::CFG_ROWS_W;
  localparam int CW     = CNT_W + 1;
  localparam int RW     = RCNT_W + 1;
  localparam int TW     = COL_W + 1;
  localparam int PW     = ROW_W + CNT_W + 1;
  localparam int RES_W  = $bits(tcur_pkg::result_t);

  typedef struct packed {
    logic              do_write;
    logic              do_scroll;
    logic [IDX_W-1:0]  idx;
    logic [15:0]       entry;
    logic [CNT_W-1:0]  cols;
    logic [RCNT_W-1:0] rows;
  } cmd_t;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic [CE-1:0]     cfg_c;
  logic [RE-1:0]     cfg_r;
  logic [CNT_W-1:0]  cols;
  logic [RCNT_W-1:0] rows;
  logic [COL_W-1:0]  col_s, pos_col;
  logic [ROW_W-1:0]  row_s, pos_row, nl_row;
  logic              last_row;
  logic [TW-1:0]     tab_col, inc_col;
  logic              tab_wrap, inc_wrap;
  logic              written, scr;
  logic [15:0]       entry;
  logic [PW-1:0]     prod;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W+12:0] idx_ext;
  logic [COL_W+6:0]  col_ext;
  logic [ROW_W+5:0]  row_ext;
  logic              in_acc, res_full, res_empty;
  cmd_t              cmd;
  tcur_pkg::result_t res_new;
  logic [RES_W-1:0]  res_head;

  // Saturate the configured screen size
  always_comb begin
    cfg_c = CE'(cols_cfg);
    cfg_r = RE'(rows_cfg);
    if (cols_cfg == '0) begin
      cols = CNT_W'(1);
    end else if (cfg_c > CE'(MAX_COLS)) begin
      cols = CNT_W'(MAX_COLS);
    end else begin
      cols = cfg_c[CNT_W-1:0];
    end
    if (rows_cfg == '0) begin
      rows = RCNT_W'(1);
    end else if (cfg_r > RE'(MAX_ROWS)) begin
      rows = RCNT_W'(MAX_ROWS);
    end else begin
      rows = cfg_r[RCNT_W-1:0];
    end
  end

  // Clamp the cursor into the screen and prepare the moves
  always_comb begin
    col_s    = (CW'(col_r) >= CW'(cols)) ? COL_W'(cols - CNT_W'(1)) : col_r;
    row_s    = (RW'(row_r) >= RW'(rows)) ? ROW_W'(rows - RCNT_W'(1)) : row_r;
    last_row = (RW'(row_s) == (RW'(rows) - RW'(1)));
    nl_row   = last_row ? row_s : row_s + ROW_W'(1);
    tab_col  = (TW'(col_s) | TW'(3)) + TW'(1);
    inc_col  = TW'(col_s) + TW'(1);
    tab_wrap = (CW'(tab_col) >= CW'(cols));
    inc_wrap = (CW'(inc_col) >= CW'(cols));
  end

  // Classify the character and move the cursor
  always_comb begin
    written = 1'b0;
    scr     = 1'b0;
    entry   = '0;
    col_nxt = col_s;
    row_nxt = row_s;
    pos_col = col_s;
    pos_row = row_s;
    unique case (in_char_code)
      tcur_pkg::CH_NUL: begin
      end
      tcur_pkg::CH_TAB: begin
        if (tab_wrap) begin
          col_nxt = '0;
          row_nxt = nl_row;
          scr     = last_row;
        end else begin
          col_nxt = tab_col[COL_W-1:0];
        end
      end
      tcur_pkg::CH_BACKSPACE: begin
        if (col_s == '0) begin
          if (row_s != '0) begin
            col_nxt = COL_W'(cols - CNT_W'(1));
            row_nxt = row_s - ROW_W'(1);
          end
        end else begin
          col_nxt = col_s - COL_W'(1);
        end
        pos_col = col_nxt;
        pos_row = row_nxt;
        written = 1'b1;
        entry   = tcur_pkg::BLANK_ENTRY;
      end
      tcur_pkg::CH_NEWLINE: begin
        col_nxt = '0;
        row_nxt = nl_row;
        scr     = last_row;
      end
      default: begin
        written = 1'b1;
        entry   = {in_attribute, in_char_code};
        if (inc_wrap) begin
          col_nxt = '0;
          row_nxt = nl_row;
          scr     = last_row;
        end else begin
          col_nxt = inc_col[COL_W-1:0];
        end
      end
    endcase
  end

  // Cell index of the written cell
  always_comb begin
    prod    = PW'(pos_row) * PW'(cols) + PW'(pos_col);
    idx     = prod[IDX_W-1:0];
    idx_ext = {13'b0, idx};
    col_ext = {7'b0, col_nxt};
    row_ext = {6'b0, row_nxt};
  end

  // Form the result and the store command
  always_comb begin
    res_new.cell_written = written;
    res_new.cell_index   = written ? idx_ext[12:0] : 13'b0;
    res_new.cell_entry   = entry;
    res_new.scrolled     = scr;
    res_new.cursor_col   = col_ext[6:0];
    res_new.cursor_row   = row_ext[5:0];
    cmd.do_write  = written;
    cmd.do_scroll = scr;
    cmd.idx       = idx;
    cmd.entry     = entry;
    cmd.cols      = cols;
    cmd.rows      = rows;
  end

  // Accept while the store is ready and a result slot is free
  assign in_stall = bk_status.clearing | cmd_full | res_full;
  assign in_acc   = in_valid & ~in_stall;
  assign cmd_push = in_acc & (written | scr);
  assign cmd_data = cmd;

  // Cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Hold finished results until taken
  tcur_fifo #(
    .W     (RES_W),
    .DEPTH (tcur_pkg::OUT_Q_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res_new),
    .pop       (res_valid & ~res_stall),
    .full      (res_full),
    .empty     (res_empty),
    .head_data (res_head)
  );

  assign res_valid = ~res_empty;
  assign res       = tcur_pkg::result_t'(res_head);

endmodule

`default_nettype wire

// File: rtl/tcur_back.sv
// Back of the terminal engine: owns the cell store and carries out writes and scrolls.
// Clears the store after reset and copies rows one cell per cycle on a scroll.
// Depends on tcur_pkg.
`default_nettype none

module tcur_back #(
  parameter int MAX_COLS = tcur_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tcur_pkg::DEF_MAX_ROWS
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          cmd_empty,
  input  wire logic [tcur_pkg::cmd_width(MAX_COLS, MAX_ROWS)-1:0] cmd_data,
  output logic                                               cmd_pop,
  output tcur_pkg::bk_status_t                               bk_status
);

  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int IDX_W  = $clog2(MAX_COLS * MAX_ROWS);
  localparam int CT     = IDX_W + 1;
  localparam int MW     = CNT_W + RCNT_W + 1;
  localparam int CELLS  = MAX_COLS * MAX_ROWS;

  typedef struct packed {
    logic              do_write;
    logic              do_scroll;
    logic [IDX_W-1:0]  idx;
    logic [15:0]       entry;
    logic [CNT_W-1:0]  cols;
    logic [RCNT_W-1:0] rows;
  } cmd_t;

  logic [15:0] mem [CELLS];

  tcur_pkg::bk_state_t state_r, state_nxt;
  logic [CT-1:0]    cnt_r, cnt_nxt;
  logic [CT-1:0]    moved_r, moved_nxt;
  logic [CT-1:0]    end_r, end_nxt;
  logic [CNT_W-1:0] cols_r, cols_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [15:0]      rd_data_r;

  cmd_t             cmd;
  logic [MW-1:0]    area;
  logic [CT-1:0]    rd_sum;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]      mem_wdata;

  assign cmd = cmd_t'(cmd_data);
  assign bk_status.clearing = (state_r == tcur_pkg::BK_CLEAR);

  // Sequence the clear after reset, store writes, row copies and the blank fill
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    moved_nxt     = moved_r;
    end_nxt       = end_r;
    cols_nxt      = cols_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[IDX_W-1:0];
    mem_wdata     = tcur_pkg::CLEAR_ENTRY;
    area          = MW'(cmd.rows) * MW'(cmd.cols);
    rd_sum        = cnt_r + CT'(cols_r);
    mem_raddr     = rd_sum[IDX_W-1:0];
    unique case (state_r)
      tcur_pkg::BK_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + CT'(1);
        if (cnt_r == CT'(CELLS - 1)) begin
          state_nxt = tcur_pkg::BK_IDLE;
        end
      end
      tcur_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.do_write) begin
            mem_we    = 1'b1;
            mem_waddr = cmd.idx;
            mem_wdata = cmd.entry;
          end
          if (cmd.do_scroll) begin
            end_nxt   = area[CT-1:0];
            moved_nxt = area[CT-1:0] - CT'(cmd.cols);
            cols_nxt  = cmd.cols;
            cnt_nxt   = '0;
            state_nxt = tcur_pkg::BK_COPY;
          end
        end
      end
      tcur_pkg::BK_COPY: begin
        // drain the copy fetched last cycle
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = rd_data_r;
        end
        if (cnt_r < moved_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt       = cnt_r + CT'(1);
        end else begin
          state_nxt = tcur_pkg::BK_BLANK;
        end
      end
      tcur_pkg::BK_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = tcur_pkg::BLANK_ENTRY;
        cnt_nxt   = cnt_r + CT'(1);
        if ((cnt_r + CT'(1)) == end_r) begin
          state_nxt = tcur_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = tcur_pkg::BK_IDLE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcur_pkg::BK_CLEAR;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    moved_r     <= moved_nxt;
    end_r       <= end_nxt;
    cols_r      <= cols_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

  // Cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

endmodule

`default_nettype wire

// File: rtl/text_terminal_cursor_engine_top.sv
// Text terminal cursor engine, top level. Each accepted item's result is registered in a result queue.
// Throughput: one item per cycle while no stall holds the input; a scroll keeps the store
// sequencer busy, and items stall once the 4-entry command queue fills behind it.
// Reset: synchronous, active low; the cursor goes to 0,0, the registers to 80 columns and
// 25 rows, then a clearing pass over all MAX_COLS*MAX_ROWS cells zeroes the store, no items taken.
`default_nettype none

module text_terminal_cursor_engine_top #(
  parameter int MAX_COLS = tcur_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tcur_pkg::DEF_MAX_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [7:0]  in_attribute,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_cell_written,
  output logic [12:0]      out_cell_index,
  output logic [15:0]      out_cell_entry,
  output logic             out_scrolled,
  output logic [6:0]       out_cursor_col,
  output logic [5:0]       out_cursor_row,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CMD_W = tcur_pkg::cmd_width(MAX_COLS, MAX_ROWS);

  logic [tcur_pkg::CFG_COLS_W-1:0] cols_cfg_r;
  logic [tcur_pkg::CFG_ROWS_W-1:0] rows_cfg_r;
  logic                 cfg_wr;
  logic                 cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic [CMD_W-1:0]     cmd_wdata, cmd_rdata;
  tcur_pkg::bk_status_t bk_status;
  tcur_pkg::result_t    res;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= tcur_pkg::CFG_COLS_RESET;
      rows_cfg_r <= tcur_pkg::CFG_ROWS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tcur_pkg::REG_COLS: cols_cfg_r <= pwdata[tcur_pkg::CFG_COLS_W-1:0];
        tcur_pkg::REG_ROWS: rows_cfg_r <= pwdata[tcur_pkg::CFG_ROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[2])
      tcur_pkg::REG_COLS: prdata = {24'b0, cols_cfg_r};
      tcur_pkg::REG_ROWS: prdata = {25'b0, rows_cfg_r};
      default:            prdata = '0;
    endcase
  end

  tcur_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_attribute (in_attribute),
    .cols_cfg     (cols_cfg_r),
    .rows_cfg     (rows_cfg_r),
    .bk_status    (bk_status),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_wdata),
    .res_valid    (out_valid),
    .res_stall    (out_stall),
    .res          (res)
  );

  // Store commands between front and back
  tcur_fifo #(
    .W     (CMD_W),
    .DEPTH (tcur_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_wdata),
    .pop       (cmd_pop),
    .full      (cmd_full),
    .empty     (cmd_empty),
    .head_data (cmd_rdata)
  );

  tcur_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .bk_status (bk_status)
  );

  // Result fields
  assign out_cell_written = res.cell_written;
  assign out_cell_index   = res.cell_index;
  assign out_cell_entry   = res.cell_entry;
  assign out_scrolled     = res.scrolled;
  assign out_cursor_col   = res.cursor_col;
  assign out_cursor_row   = res.cursor_row;

endmodule

`default_nettype wire

// File: verif/cursor_scoreboard_pkg.sv
// Scoreboard for the text terminal cursor engine: cursor predictor plus result check.
// Depends on tcur_pkg for the result record, the character codes and the register widths.
package cursor_scoreboard_pkg;
  import tcur_pkg::*;

  localparam int SCREEN_COLS_MAX = DEF_MAX_COLS;
  localparam int SCREEN_ROWS_MAX = DEF_MAX_ROWS;

  class cursor_scoreboard;
    logic [CFG_COLS_W-1:0] cols_setting;
    logic [CFG_ROWS_W-1:0] rows_setting;
    int col_pos;
    int row_pos;
    result_t results_due[$];
    int mismatches;

    function new();
      cols_setting = CFG_COLS_RESET;
      rows_setting = CFG_ROWS_RESET;
      col_pos = 0;
      row_pos = 0;
      mismatches = 0;
    endfunction

    function void set_columns(logic [7:0] value);
      cols_setting = value[CFG_COLS_W-1:0];
    endfunction

    function void set_rows(logic [7:0] value);
      rows_setting = value[CFG_ROWS_W-1:0];
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // Go to column 0 of the next row; report a scroll when it falls off the bottom.
    // The store contents never reach the result port, so only the cursor is tracked.
    function logic line_feed(int usable_rows);
      col_pos = 0;
      row_pos++;
      if (row_pos >= usable_rows) begin
        row_pos = usable_rows - 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Predict the result of one accepted item.
    function void note_char(logic [7:0] ch, logic [7:0] attr);
      int usable_cols;
      int usable_rows;
      result_t r;
      // Saturate the registers to the legal screen size
      usable_cols = int'(cols_setting);
      if (usable_cols < 1) usable_cols = 1;
      if (usable_cols > SCREEN_COLS_MAX) usable_cols = SCREEN_COLS_MAX;
      usable_rows = int'(rows_setting);
      if (usable_rows < 1) usable_rows = 1;
      if (usable_rows > SCREEN_ROWS_MAX) usable_rows = SCREEN_ROWS_MAX;
      // Pull a cursor left outside a shrunken screen back onto it
      if (col_pos >= usable_cols) col_pos = usable_cols - 1;
      if (row_pos >= usable_rows) row_pos = usable_rows - 1;
      r = '0;
      case (ch)
        CH_NUL: ;
        CH_TAB: begin
          col_pos = (col_pos / 4 + 1) * 4;
          if (col_pos >= usable_cols) r.scrolled = line_feed(usable_rows);
        end
        CH_BACKSPACE: begin
          // At column 0 step to the end of the row above; top-left cell stays put
          if (col_pos == 0) begin
            if (row_pos != 0) begin
              col_pos = usable_cols - 1;
              row_pos--;
            end
          end else begin
            col_pos--;
          end
          r.cell_written = 1'b1;
          r.cell_index = 13'(row_pos * usable_cols + col_pos);
          r.cell_entry = BLANK_ENTRY;
        end
        CH_NEWLINE: r.scrolled = line_feed(usable_rows);
        default: begin
          r.cell_written = 1'b1;
          r.cell_index = 13'(row_pos * usable_cols + col_pos);
          r.cell_entry = {attr, ch};
          col_pos++;
          if (col_pos >= usable_cols) r.scrolled = line_feed(usable_rows);
        end
      endcase
      r.cursor_col = 7'(col_pos);
      r.cursor_row = 6'(row_pos);
      results_due.push_back(r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Check one accepted result against the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual %p", $time, got);
        return;
      end
      want = results_due.pop_front();
      compare_field("cell_written", 16'(want.cell_written), 16'(got.cell_written));
      compare_field("cell_index", 16'(want.cell_index), 16'(got.cell_index));
      compare_field("cell_entry", want.cell_entry, got.cell_entry);
      compare_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
      compare_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
      compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
    endfunction
  endclass

endpackage

// File: verif/testbench.sv
// Top-level testbench for text_terminal_cursor_engine_top: directed and random character
// streams over several screen sizes, random stalls on both channels, scoreboard check.
// Depends on tcur_pkg and cursor_scoreboard_pkg.
module testbench;
  import tcur_pkg::*;
  import cursor_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam logic [2:0] ADDR_COLUMNS = {REG_COLS, 2'b00};
  localparam logic [2:0] ADDR_ROWS = {REG_ROWS, 2'b00};

  // Opening items on the reset screen: {attribute, character}
  localparam int OPENING_COUNT = 8;
  localparam logic [15:0] OPENING_ITEMS [OPENING_COUNT] = '{
    {8'h00, CH_BACKSPACE}, {8'hFF, 8'hFF}, {8'h00, 8'h01}, {8'h3C, CH_TAB},
    {8'hA5, CH_NUL}, {8'h0F, CH_BACKSPACE}, {8'hF0, CH_NEWLINE}, {8'h5A, 8'h7F}
  };

  // Items on a 6x2 screen: tab wrap with scroll, backspace to the row above,
  // printable wrap without and with scroll, newline scroll
  localparam int NARROW_COUNT = 12;
  localparam logic [15:0] NARROW_ITEMS [NARROW_COUNT] = '{
    {8'h11, CH_TAB}, {8'h22, CH_TAB}, {8'h33, CH_BACKSPACE}, {8'h44, 8'h41},
    {8'h55, CH_NEWLINE}, {8'h66, 8'h78}, {8'h77, 8'h79}, {8'h88, 8'h7A},
    {8'h99, 8'h77}, {8'hAA, 8'h76}, {8'hBB, 8'h75}, {8'hCC, 8'h71}
  };

  // Random phases: written register values, item count, newline share in percent
  localparam int PHASES = 9;
  localparam logic [7:0] PHASE_COLS [PHASES] = '{80, 1, 6, 0, 255, 16, 128, 3, 37};
  localparam logic [7:0] PHASE_ROWS [PHASES] = '{25, 1, 2, 0, 127, 8, 4, 64, 13};
  localparam int PHASE_ITEMS [PHASES] = '{60, 80, 100, 40, 40, 100, 80, 80, 100};
  localparam int PHASE_NEWLINE_PCT [PHASES] = '{10, 20, 20, 20, 20, 20, 12, 20, 15};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = 8'h00;
  logic [7:0]  in_attribute = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_cell_written;
  logic [12:0] out_cell_index;
  logic [15:0] out_cell_entry;
  logic        out_scrolled;
  logic [6:0]  out_cursor_col;
  logic [5:0]  out_cursor_row;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int cycles_run = 0;
  int sender_calm = 0;
  int receiver_calm = 0;
  cursor_scoreboard board = new();

  text_terminal_cursor_engine_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_attribute     (in_attribute),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cell_written (out_cell_written),
    .out_cell_index   (out_cell_index),
    .out_cell_entry   (out_cell_entry),
    .out_scrolled     (out_scrolled),
    .out_cursor_col   (out_cursor_col),
    .out_cursor_row   (out_cursor_row),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
  end

  // Random idle gap per item, with occasional stretches of no idling
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 9);
  endfunction

  // Mostly printable bytes over the full range, plus control codes
  function automatic logic [7:0] draw_char(input int newline_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return CH_NUL;
    if (pick < 16) return CH_BACKSPACE;
    if (pick < 28) return CH_TAB;
    if (pick < 28 + newline_pct) return CH_NEWLINE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one item, hold it until accepted, then predict its result
  task automatic send_item(input logic [7:0] ch, input logic [7:0] attr);
    int gap;
    gap = draw_gap(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= ch;
    in_attribute <= attr;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_char(ch, attr);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle until pready, then psel drops back to idle;
  // upper data bits carry noise
  task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
    logic [31:0] noise;
    noise = $urandom();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {noise[31:8], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rows);
    write_reg(ADDR_COLUMNS, cols);
    board.set_columns(cols);
    write_reg(ADDR_ROWS, rows);
    board.set_rows(rows);
  endtask

  // Stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (OPENING_ITEMS[i]) send_item(OPENING_ITEMS[i][7:0], OPENING_ITEMS[i][15:8]);
    settle();
    set_geometry(8'd6, 8'd2);
    foreach (NARROW_ITEMS[i]) send_item(NARROW_ITEMS[i][7:0], NARROW_ITEMS[i][15:8]);
    settle();
    for (int p = 0; p < PHASES; p++) begin
      set_geometry(PHASE_COLS[p], PHASE_ROWS[p]);
      repeat (PHASE_ITEMS[p]) begin
        send_item(draw_char(PHASE_NEWLINE_PCT[p]), 8'($urandom_range(0, 255)));
      end
      settle();
    end
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stalls, two long hold-offs to back up the block
  initial begin
    int hold;
    int seen;
    result_t got;
    seen = 0;
    @(posedge clk);
    forever begin
      if (seen == 120 || seen == 400) begin
        hold = HOLD_OFF_CYCLES;
      end else begin
        hold = draw_gap(receiver_calm);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {out_cell_written, out_cell_index, out_cell_entry, out_scrolled,
             out_cursor_col, out_cursor_row};
      board.check_result(got);
      seen++;
    end
  end

  // Watchdog
  initial begin
    wait (cycles_run >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
